// File: hw/rtl/assert_macros.svh
// Assertion macros for the note detector RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// check an implication in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/fnc_pkg.sv
// Package for the note detector: widths, ratio table, state and command types.
// Depends on nothing.
package fnc_pkg;
	localparam int FREQ_W = 22;
	localparam int REF_W = 9;
	localparam int RATIO_SHIFT = 29;
	localparam int DEF_FRAC_BITS = 8;
	localparam int DEF_MAX_OCTAVE = 9;
	localparam int RATIO_W = 26;
	localparam int PROD_W = REF_W + RATIO_W;
	localparam int VAL_W = 64;
	localparam int QUO_W = 7;
	localparam logic [3:0] LAST_NOTE = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PROD, ST_OCT, ST_SEMI, ST_PREP, ST_DIV, ST_DONE
	} fnc_state_t;

	typedef struct packed {
		logic load;
		logic prod;
		logic oct_step;
		logic semi_step;
		logic prep;
		logic div_step;
		logic finish;
	} fnc_cmd_t;

	typedef struct packed {
		logic oct_done;
		logic semi_done;
		logic div_done;
	} fnc_stat_t;

	function automatic logic [RATIO_W-1:0] ratio(input logic [3:0] k);
		logic [RATIO_W-1:0] r;
		case (k)
			4'd0: r = 26'd19951585;
			4'd1: r = 26'd21137968;
			4'd2: r = 26'd22394897;
			4'd3: r = 26'd23726566;
			4'd4: r = 26'd25137421;
			4'd5: r = 26'd26632170;
			4'd6: r = 26'd28215802;
			4'd7: r = 26'd29893600;
			4'd8: r = 26'd31671166;
			4'd9: r = 26'd33554432;
			4'd10: r = 26'd35549682;
			4'd11: r = 26'd37663576;
			4'd12: r = 26'd39903170;
			default: r = 26'd0;
		endcase
		return r;
	endfunction
endpackage

// File: hw/rtl/fnc_ctrl.sv
// Controller for the note detector: sequences product, searches and division.
// Depends on fnc_pkg.
module fnc_ctrl import fnc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  fnc_stat_t stat,
	output fnc_cmd_t  cmd,
	output logic      busy,
	output logic      done
);
	fnc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d = ST_OCT;
			end
			ST_OCT: begin
				cmd.oct_step = 1'b1;
				if (stat.oct_done) state_d = ST_SEMI;
			end
			ST_SEMI: begin
				cmd.semi_step = 1'b1;
				if (stat.semi_done) state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				done = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// File: hw/rtl/fnc_datapath.sv
// Datapath for the note detector: note frequencies, searches, restoring divider.
// Depends on fnc_pkg.
module fnc_datapath import fnc_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int MAX_OCTAVE = DEF_MAX_OCTAVE
) (
	input  logic              clk,
	input  logic [REF_W-1:0]  ref_hz,
	input  logic [FREQ_W-1:0] frequency_in,
	input  fnc_cmd_t          cmd,
	output fnc_stat_t         stat,
	output logic [3:0]        note_index,
	output logic [3:0]        octave,
	output logic signed [6:0] cents_offset,
	output logic              out_of_range
);
	localparam logic [3:0] MAX_OCT = 4'(MAX_OCTAVE);
	localparam logic [3:0] DIV_LAST = 4'(QUO_W);

	logic [VAL_W-1:0] f_q, lo_q, hi_q, diff_q, wid_q, rem_q, dsr_q;
	logic [3:0] oct_q, k_q, div_cnt_q;
	logic [QUO_W-1:0] quo_q;
	logic up_q, below_q, above_q;
	logic [3:0] k_sel;
	logic [PROD_W-1:0] prod;
	logic [VAL_W-1:0] next_oct, semi_val, d_lo, d_hi, num;
	logic rem_ge;
	logic [5:0] sat;

	assign k_sel = cmd.semi_step ? k_q + 4'd1 : 4'd0;
	assign prod = PROD_W'(ref_hz) * PROD_W'(ratio(k_sel));
	assign next_oct = lo_q << 1;
	assign semi_val = VAL_W'(prod) << oct_q;
	assign d_lo = f_q - lo_q;
	assign d_hi = hi_q - f_q;
	assign num = (diff_q << 6) + (diff_q << 5) + (diff_q << 2);
	assign rem_ge = rem_q >= dsr_q;
	assign sat = (quo_q > 7'd50) ? 6'd50 : quo_q[5:0];

	assign stat.oct_done = below_q || above_q || oct_q == MAX_OCT || next_oct > f_q;
	assign stat.semi_done = below_q || above_q || k_q == LAST_NOTE || semi_val > f_q;
	assign stat.div_done = div_cnt_q == DIV_LAST;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			f_q <= VAL_W'(frequency_in) << (RATIO_SHIFT - FRAC_BITS);
			k_q <= 4'd0;
			oct_q <= 4'd0;
			below_q <= 1'b0;
			above_q <= 1'b0;
		end
		if (cmd.prod) begin
			lo_q <= VAL_W'(prod);
			below_q <= f_q < VAL_W'(prod);
			above_q <= f_q >= (VAL_W'(prod) << (MAX_OCTAVE + 1));
		end
		if (cmd.oct_step && !stat.oct_done) begin
			lo_q <= next_oct;
			oct_q <= oct_q + 4'd1;
		end
		if (cmd.semi_step) begin
			if (stat.semi_done) begin
				hi_q <= semi_val;
			end else begin
				lo_q <= semi_val;
				k_q <= k_q + 4'd1;
			end
		end
		if (cmd.prep) begin
			up_q <= d_hi < d_lo;
			diff_q <= (d_hi < d_lo) ? d_hi : d_lo;
			wid_q <= (hi_q == lo_q) ? VAL_W'(1) : hi_q - lo_q;
			div_cnt_q <= '0;
		end
		if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 4'd1;
			if (div_cnt_q == '0) begin
				rem_q <= num;
				dsr_q <= wid_q << (QUO_W - 1);
				quo_q <= '0;
			end else begin
				if (rem_ge) rem_q <= rem_q - dsr_q;
				dsr_q <= dsr_q >> 1;
				quo_q <= {quo_q[QUO_W-2:0], rem_ge};
			end
		end
		if (cmd.finish) begin
			if (below_q) begin
				note_index <= 4'd0; octave <= 4'd0;
				cents_offset <= -7'sd50; out_of_range <= 1'b1;
			end else if (above_q || (up_q && k_q == LAST_NOTE && oct_q == MAX_OCT)) begin
				note_index <= LAST_NOTE; octave <= MAX_OCT;
				cents_offset <= 7'sd50; out_of_range <= 1'b1;
			end else if (up_q) begin
				note_index <= (k_q == LAST_NOTE) ? 4'd0 : k_q + 4'd1;
				octave <= (k_q == LAST_NOTE) ? oct_q + 4'd1 : oct_q;
				cents_offset <= -$signed({1'b0, sat});
				out_of_range <= 1'b0;
			end else begin
				note_index <= k_q; octave <= oct_q;
				cents_offset <= $signed({1'b0, sat});
				out_of_range <= 1'b0;
			end
		end
	end
endmodule

// File: hw/rtl/frequency_to_note_cents.sv
// Top level of the note detector: controller, datapath, reference register.
// Depends on fnc_pkg, fnc_ctrl, fnc_datapath and assert_macros.svh.
// Sequence: product, octave search, semitone search, prep, divide; the searches vary in length.
// One item at a time; start is taken in the result cycle, no new item before the last is done.
// Result strobe lasts one cycle; the receiver cannot stall.
// Reset clears the controller and sets the reference to 440 Hz.
`include "assert_macros.svh"
module frequency_to_note_cents import fnc_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int MAX_OCTAVE = DEF_MAX_OCTAVE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [FREQ_W-1:0] frequency,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [REF_W-1:0]  cfg_data,
	output logic              result_valid,
	output logic [3:0]        note_index,
	output logic [3:0]        octave,
	output logic signed [6:0] cents_offset,
	output logic              out_of_range
);
	logic [REF_W-1:0] ref_q;
	fnc_cmd_t cmd;
	fnc_stat_t stat;
	logic done;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ref_q <= REF_W'(440);
		else if (cfg_valid) ref_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= done;
	end

	fnc_ctrl u_ctrl (.clk, .arst_n, .start, .stat, .cmd, .busy, .done);
	fnc_datapath #(.FRAC_BITS(FRAC_BITS), .MAX_OCTAVE(MAX_OCTAVE)) u_dp (
		.clk, .ref_hz(ref_q), .frequency_in(frequency), .cmd, .stat,
		.note_index, .octave, .cents_offset, .out_of_range
	);

	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_IMPL(a_done_busy, clk, arst_n, done, busy)
	`ASSERT_NEXT(a_strobe_one, clk, arst_n, result_valid, !result_valid)
endmodule
